// ----- design/ktma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktma_pkg
// Shared types, constants and helpers for the key to mesh address mapper.
// ----------------------------------------------------------------------------
package ktma_pkg;

    localparam logic [7:0] ADDR_PREFIX = 8'h02;
    localparam logic [7:0] TOP_BIT     = 8'h80;

    // work kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HDR,
        CMD_DATA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] value;      // ones count for a header, packed byte for data
        logic       key_end;    // final key byte: pad the address afterwards
    } t_cmd;

    typedef enum logic [1:0] {
        BK_HEAD,
        BK_ONES,
        BK_PAD
    } t_bk_state;

    // number of leading one bits, msb first, 0..8
    function automatic logic [3:0] lead_ones(input logic [7:0] v);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run && ((v & (TOP_BIT >> i)) != 8'h00)) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- design/ktma_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktma_front
// Inverts key bytes, counts leading ones and repacks the tail bits.
// ----------------------------------------------------------------------------
module ktma_front #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_key_byte,
    output ktma_pkg::t_cmd     o_cmd,
    output logic               o_cmd_push
);

    localparam int BS_W = $clog2(KEY_BYTES);

    logic [BS_W-1:0] r_bytes_seen, n_bytes_seen;
    logic            r_zero_found, n_zero_found;
    logic [7:0]      r_ones, n_ones;
    logic [7:0]      r_acc, n_acc;
    logic [2:0]      r_held, n_held;

    logic [7:0]      inv;
    logic [3:0]      lead;
    logic [15:0]     joined;
    logic            key_end;
    ktma_pkg::t_cmd  cmd;

    always_comb begin
        inv          = ~i_key_byte;
        lead         = ktma_pkg::lead_ones(inv);
        joined       = {r_acc, inv} >> r_held;
        key_end      = (r_bytes_seen == BS_W'(KEY_BYTES - 1));
        n_bytes_seen = r_bytes_seen + 1'b1;
        n_zero_found = r_zero_found;
        n_ones       = r_ones;
        n_acc        = r_acc;
        n_held       = r_held;
        cmd.kind     = ktma_pkg::CMD_NONE;
        cmd.value    = joined[7:0];
        cmd.key_end  = key_end;

        if (r_zero_found) begin
            // a whole byte of tail bits completes exactly one packed byte
            cmd.kind = ktma_pkg::CMD_DATA;
            n_acc    = inv;
        end else if (lead == 4'd8) begin
            n_ones = r_ones + 8'd8;
            if (key_end) begin
                cmd.kind = ktma_pkg::CMD_HDR;
            end
        end else begin
            n_ones       = r_ones + {4'd0, lead};
            n_zero_found = 1'b1;
            n_acc        = inv;
            n_held       = 3'(4'd7 - lead);
            cmd.kind     = ktma_pkg::CMD_HDR;
        end
        cmd.value = (cmd.kind == ktma_pkg::CMD_HDR) ? n_ones : joined[7:0];

        if (key_end) begin
            n_bytes_seen = '0;
            n_zero_found = 1'b0;
            n_ones       = 8'd0;
            n_held       = 3'd0;
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && ((cmd.kind != ktma_pkg::CMD_NONE) || key_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_zero_found <= 1'b0;
            r_ones       <= 8'd0;
            r_held       <= 3'd0;
        end else if (i_accept) begin
            r_bytes_seen <= n_bytes_seen;
            r_zero_found <= n_zero_found;
            r_ones       <= n_ones;
            r_held       <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ----- design/ktma_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktma_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ktma_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ktma_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output ktma_pkg::t_cmd       o_head,
    output logic                 o_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ktma_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- design/ktma_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktma_back
// Turns queued commands into address bytes, limits and pads the address.
// ----------------------------------------------------------------------------
module ktma_back #(
    parameter int ADDR_BYTES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ktma_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_addr_byte,
    output logic               o_addr_last
);

    localparam int CNT_W = $clog2(ADDR_BYTES + 1);

    ktma_pkg::t_bk_state r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic                emit;
    logic [7:0]          emit_byte;
    logic                can_out;
    logic                go;
    logic                addr_full;

    assign addr_full = (r_cnt == CNT_W'(ADDR_BYTES));
    assign can_out   = !r_out_valid || i_pop;
    assign go        = i_cmd_valid && (!emit || can_out);

    // output decode
    always_comb begin
        emit      = 1'b0;
        emit_byte = 8'h00;
        if (i_cmd_valid) begin
            unique case (r_state)
                ktma_pkg::BK_HEAD: begin
                    if (i_cmd.kind == ktma_pkg::CMD_HDR) begin
                        emit      = 1'b1;
                        emit_byte = ktma_pkg::ADDR_PREFIX;
                    end else if (i_cmd.kind == ktma_pkg::CMD_DATA) begin
                        emit      = !addr_full;
                        emit_byte = i_cmd.value;
                    end
                end
                ktma_pkg::BK_ONES: begin
                    emit      = 1'b1;
                    emit_byte = i_cmd.value;
                end
                ktma_pkg::BK_PAD: begin
                    emit      = !addr_full;
                    emit_byte = 8'h00;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd_pop = 1'b0;
        if (go) begin
            if (emit) begin
                n_cnt = r_cnt + 1'b1;
            end
            unique case (r_state)
                ktma_pkg::BK_HEAD: begin
                    if (i_cmd.kind == ktma_pkg::CMD_HDR) begin
                        n_state = ktma_pkg::BK_ONES;
                    end else if (i_cmd.key_end) begin
                        n_state = ktma_pkg::BK_PAD;
                    end else begin
                        o_cmd_pop = 1'b1;
                    end
                end
                ktma_pkg::BK_ONES: begin
                    if (i_cmd.key_end) begin
                        n_state = ktma_pkg::BK_PAD;
                    end else begin
                        n_state   = ktma_pkg::BK_HEAD;
                        o_cmd_pop = 1'b1;
                    end
                end
                ktma_pkg::BK_PAD: begin
                    if (addr_full) begin
                        n_state   = ktma_pkg::BK_HEAD;
                        n_cnt     = '0;
                        o_cmd_pop = 1'b1;
                    end
                end
                default: begin
                    n_state = ktma_pkg::BK_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ktma_pkg::BK_HEAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (can_out) begin
                r_out_valid <= i_cmd_valid && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_out && emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= (r_cnt == CNT_W'(ADDR_BYTES - 1));
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_addr_byte = r_out_byte;
    assign o_addr_last = r_out_last;

endmodule
`default_nettype wire

// ----- design/key_to_mesh_address.sv -----
`timescale 1ns / 1ps
`default_nettype none
// an address byte passes through the command queue and the back output register before it shows on the result ports
// throughput: one key byte per cycle while full is low; the back sends a header as a prefix and a count byte
// the final key byte makes the back pad the address with zero bytes up to ADDR_BYTES and then wrap up
// the back output register and the command queue set the sustained rate
// reset: synchronous active-low i_rst_n clears counters, queue and output valid
// ----------------------------------------------------------------------------
// key_to_mesh_address
// Streams a public key in and emits a fixed-length mesh address.
// ----------------------------------------------------------------------------
module key_to_mesh_address #(
    parameter int KEY_BYTES  = 32,
    parameter int ADDR_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // key byte side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_key_byte,
    // address byte side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_addr_byte,
    output logic            o_addr_last
);

    // a few entries let the front run ahead while the back sends a header or padding
    localparam int QUEUE_DEPTH = 4;

    ktma_pkg::t_cmd front_cmd;
    logic           front_push;
    ktma_pkg::t_cmd head_cmd;
    logic           head_valid;
    logic           head_pop;
    logic           q_full;
    logic           accept;

    // key byte transfer
    assign accept = push && !q_full;
    assign full   = q_full;

    // front: inversion, ones count, bit repacking
    ktma_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_key_byte (i_key_byte),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push)
    );

    // decoupling queue; a push only happens on an accepted byte, so never when full
    ktma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (head_pop),
        .o_head  (head_cmd),
        .o_valid (head_valid)
    );

    // back: header bytes, length limit, zero padding, last flag
    ktma_back #(
        .ADDR_BYTES (ADDR_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (head_valid),
        .o_cmd_pop   (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_addr_byte (o_addr_byte),
        .o_addr_last (o_addr_last)
    );

endmodule
`default_nettype wire

// ----- bench/key_to_mesh_address_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_to_mesh_address_tb
// Streams whole public keys into the mapper with random push gaps and pop
// stalls, predicts every address byte from the inverted key bits and checks
// each popped byte and its last flag in order.
// ----------------------------------------------------------------------------
module key_to_mesh_address_tb;

    localparam int KEY_LEN      = 32;
    localparam int ADDR_LEN     = 16;
    localparam int KEY_BITS     = KEY_LEN * 8;
    localparam int RANDOM_KEYS  = 7;      // plus the directed keys, about 320 bytes in all
    localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the last address bytes
    localparam int SETTLE_TIME  = 24;     // extra wait after the drain to catch stray address bytes
    localparam logic [7:0] PAD_BYTE = 8'h00;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_key_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_addr_byte;
    logic       o_addr_last;

    // tracks the mapper state and holds the address bytes still owed
    class addr_scoreboard;
        typedef struct {
            logic [7:0] addr_byte;
            logic       addr_last;
        } addr_entry_t;

        addr_entry_t addr_q[$];
        logic [5:0]  keys_taken;    // key bytes of the current key
        logic        zero_seen;     // first zero bit already dropped
        logic [7:0]  lead_count;    // leading ones, wraps at 256
        logic [7:0]  packer;        // tail bits being packed msb first
        logic [2:0]  packed_bits;
        logic [4:0]  emitted;       // address bytes produced for this key
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            keys_taken  = '0;
            zero_seen   = 1'b0;
            lead_count  = '0;
            packer      = '0;
            packed_bits = '0;
            emitted     = '0;
        endfunction

        // bytes past the end of the address are simply dropped
        function void emit(logic [7:0] value);
            addr_entry_t e;
            if (emitted >= ADDR_LEN) return;
            emitted++;
            e.addr_byte = value;
            e.addr_last = (emitted == ADDR_LEN);
            addr_q.push_back(e);
        endfunction

        function void emit_header();
            if (emitted == 0) begin
                emit(ktma_pkg::ADDR_PREFIX);
                emit(lead_count);
            end
        endfunction

        function void note_key_byte(logic [7:0] kb);
            logic [7:0] inv;
            logic       b;
            inv = ~kb;
            for (int i = 7; i >= 0; i--) begin
                b = inv[i];
                if (!zero_seen) begin
                    if (b) begin
                        lead_count++;
                    end else begin
                        zero_seen = 1'b1;
                        emit_header();
                    end
                end else begin
                    packer = {packer[6:0], b};
                    packed_bits++;
                    // three bit counter wraps to zero on the eighth bit
                    if (packed_bits == 0) emit(packer);
                end
            end
            keys_taken++;
            if (keys_taken >= KEY_LEN) begin
                emit_header();
                while (emitted < ADDR_LEN) emit(PAD_BYTE);
                clear();
            end
        endfunction

        function void check_addr(logic [7:0] got_byte, logic got_last);
            addr_entry_t e;
            if (addr_q.size() == 0) begin
                $display("%0t: unexpected address byte, actual %h last %b",
                         $time, got_byte, got_last);
                errors++;
                return;
            end
            e = addr_q.pop_front();
            if (got_byte !== e.addr_byte) begin
                $display("%0t: addr_byte expected %h actual %h", $time, e.addr_byte, got_byte);
                errors++;
            end
            if (got_last !== e.addr_last) begin
                $display("%0t: addr_last expected %b actual %b", $time, e.addr_last, got_last);
                errors++;
            end
        endfunction

        function int pending();
            return addr_q.size();
        endfunction
    endclass

    addr_scoreboard sb = new();

    key_to_mesh_address #(
        .KEY_BYTES  (KEY_LEN),
        .ADDR_BYTES (ADDR_LEN)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_key_byte  (i_key_byte),
        .empty       (empty),
        .pop         (pop),
        .o_addr_byte (o_addr_byte),
        .o_addr_last (o_addr_last)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // idle length between transfers: mostly none or short, now and then long
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one key byte transfer; called and returns on a falling edge
    task automatic send_key_byte(input logic [7:0] kb, input bit steady);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push       <= 1'b1;
        i_key_byte <= kb;
        do @(posedge i_clk); while (full);
        sb.note_key_byte(kb);
        @(negedge i_clk);
    endtask

    // whole key whose inverted form starts with lead ones and then a zero;
    // lead of KEY_BITS gives the all-ones inverted key
    task automatic send_key(input int lead);
        logic [KEY_BITS-1:0] inv_key;
        bit                  steady;
        for (int w = 0; w < KEY_BITS / 32; w++) inv_key[w*32 +: 32] = $urandom();
        for (int i = 0; i < lead && i < KEY_BITS; i++) inv_key[KEY_BITS-1-i] = 1'b1;
        if (lead < KEY_BITS) inv_key[KEY_BITS-1-lead] = 1'b0;
        // some keys go through back to back with no push gaps
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < KEY_LEN; k++) begin
            send_key_byte(~inv_key[KEY_BITS-1-8*k -: 8], steady);
        end
    endtask

    // address side: random pop stalls, with stretches of steady popping
    initial begin
        int gap;
        int run_left;
        bit steady;
        run_left = 0;
        steady   = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (run_left == 0) begin
                steady   = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(8, 40);
            end
            gap = pick_gap(steady);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_addr(o_addr_byte, o_addr_last);
            run_left--;
            @(negedge i_clk);
        end
    end

    // main sequence
    initial begin
        int lead;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        i_key_byte = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: all ones inverted key, so the count wraps to zero and
        // the header comes only with the final byte followed by padding
        send_key(KEY_BITS);
        // directed: 255 leading ones, zero bit is the very last key bit
        send_key(KEY_BITS - 1);
        // directed: zero bit first, address filled long before the key ends
        send_key(0);

        // random keys: early headers, headers anywhere, late headers and all-ones keys
        for (int n = 0; n < RANDOM_KEYS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: lead = $urandom_range(0, 8);
                4, 5, 6:    lead = $urandom_range(0, KEY_BITS - 1);
                7, 8:       lead = $urandom_range(100, KEY_BITS - 1);
                default:    lead = KEY_BITS;
            endcase
            send_key(lead);
        end
        push <= 1'b0;

        // drain whatever is still owed, then watch for stray bytes
        for (int c = 0; c < DRAIN_LIMIT && sb.pending() != 0; c++) @(posedge i_clk);
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d address bytes never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("key_to_mesh_address_tb: clean");
        end else begin
            $display("key_to_mesh_address_tb: errors");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10000000;
        $display("%0t: timeout", $time);
        $display("key_to_mesh_address_tb: errors");
        $finish;
    end

endmodule
